/* sv/updf_pkg.sv */
// Package for the SN-UNITDATA fragmenter: types, constants and register codes.
`timescale 1ns / 1ps

package updf_pkg;

    // Sizes and fixed field widths
    localparam int NSAPI_COUNT   = 16;
    localparam int MAX_PDU_BYTES = 2048;
    localparam int NSAPI_W       = 4;
    localparam int LEN_W         = 11;
    localparam int NPDU_W        = 12;
    localparam int SEG_W         = 4;
    localparam int HDR_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // Protocol constants
    localparam logic [LEN_W-1:0]  N201_FLOOR   = LEN_W'(140);
    localparam logic [LEN_W-1:0]  PDU_LEN_MAX  = LEN_W'(MAX_PDU_BYTES - 1);
    localparam logic [HDR_W-1:0]  HDR_LEN_FIRST = HDR_W'(4);
    localparam logic [HDR_W-1:0]  HDR_LEN_LATER = HDR_W'(3);
    localparam logic [SEG_W-1:0]  SEG_LAST     = SEG_W'(15);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LLC_MAX_INFO_LEN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NSAPI_MASK = CFG_IDX_W'(1);

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_INACTIVE = 1'b1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_FRAG
    } t_state;

endpackage

/* sv/updf_if.sv */
// Channel interfaces: transmit request in, fragment descriptor out.
`timescale 1ns / 1ps

interface updf_req_if;
    import updf_pkg::*;
    logic               valid;
    logic               ready;
    logic [NSAPI_W-1:0] nsapi;
    logic [LEN_W-1:0]   pdu_length;

    modport source (output valid, output nsapi, output pdu_length, input ready);
    modport sink   (input valid, input nsapi, input pdu_length, output ready);
endinterface

interface updf_frag_if;
    import updf_pkg::*;
    logic              valid;
    logic              ready;
    logic              status;
    logic              first_flag;
    logic              more_flag;
    logic [SEG_W-1:0]  segment_number;
    logic [NPDU_W-1:0] npdu_number;
    logic [LEN_W-1:0]  payload_offset;
    logic [LEN_W-1:0]  payload_length;
    logic [HDR_W-1:0]  header_length;
    logic              last_result;

    modport source (output valid, output status, output first_flag, output more_flag,
                    output segment_number, output npdu_number, output payload_offset,
                    output payload_length, output header_length, output last_result,
                    input ready);
    modport sink   (input valid, input status, input first_flag, input more_flag,
                    input segment_number, input npdu_number, input payload_offset,
                    input payload_length, input header_length, input last_result,
                    output ready);
endinterface

/* sv/unitdata_pdu_fragmenter_top.sv */
// Top level of the SN-UNITDATA fragmenter: request capture, fragment sequencer, counters.
//
// Usage:
//   i_req  : transmit requests (nsapi, pdu_length), valid/ready handshake.
//   o_frag : fragment descriptors, one per SN-UNITDATA fragment, valid/ready.
//   i_cfg_* : register writes (0 = N201-U, 1 = active NSAPI mask), taken
//            whenever i_cfg_we is high; write only while the block is idle.
// A request is taken in the idle state only. One subtract-and-compare unit
// then cuts the N-PDU, producing one fragment per cycle into the output
// register while the receiver takes them. A taken request is first held in
// the working registers, then its first descriptor goes into the output
// register. A request of N fragments (1 to 16, an inactive NSAPI gives one
// error descriptor) is limited by the single fragment unit, stepped once per fragment.
// The next request may be taken while the last descriptor still waits.
// When the receiver stalls, the output register holds and the sequencer waits.
// Reset (synchronous, active low) sets N201-U to 500, clears the mask and all
// N-PDU counters, and empties the output register.
`timescale 1ns / 1ps

module unitdata_pdu_fragmenter_top
    import updf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    updf_req_if.sink              i_req,
    updf_frag_if.source           o_frag
);

    // Configuration and counters
    logic [LEN_W-1:0]       r_n201;
    logic [NSAPI_COUNT-1:0] r_mask;
    logic [NPDU_W-1:0]      r_npdu_cnt [NSAPI_COUNT];

    // Sequencer and working registers
    t_state             r_state, n_state;
    logic               r_err;
    logic [NSAPI_W-1:0] r_ns;
    logic [NPDU_W-1:0]  r_npdu;
    logic [LEN_W-1:0]   r_cap_first;
    logic [LEN_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_offset;
    logic [SEG_W-1:0]   r_idx;

    // Output register
    logic               r_out_valid;
    logic               r_status;
    logic               r_first;
    logic               r_more;
    logic [SEG_W-1:0]   r_seg;
    logic [NPDU_W-1:0]  r_out_npdu;
    logic [LEN_W-1:0]   r_out_off;
    logic [LEN_W-1:0]   r_out_len;
    logic [HDR_W-1:0]   r_hdr;
    logic               r_last;

    // Combinational control
    logic              req_take;
    logic              frag_load;
    logic              frag_done;
    logic              out_free;
    logic [LEN_W-1:0]  cap;
    logic [LEN_W-1:0]  take;
    logic [LEN_W-1:0]  rem_after;
    logic              more;
    logic [LEN_W-1:0]  n201_eff;
    logic [LEN_W-1:0]  len_sat;
    logic [NSAPI_COUNT-1:0] cfg_rising;

    assign out_free = !r_out_valid || o_frag.ready;

    // Request clamps
    assign n201_eff = (r_n201 < N201_FLOOR) ? N201_FLOOR : r_n201;
    assign len_sat  = (i_req.pdu_length > PDU_LEN_MAX) ? PDU_LEN_MAX : i_req.pdu_length;

    // Shared fragment unit: one compare and one subtract per fragment
    assign cap       = (r_idx == '0) ? r_cap_first : r_cap_first + LEN_W'(1);
    assign take      = (r_rem > cap) ? cap : r_rem;
    assign rem_after = r_rem - take;
    assign more      = (rem_after != '0) && (r_idx != SEG_LAST);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_FRAG;
                end
            end
            ST_FRAG: begin
                if (out_free && (r_err || !more)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        req_take  = 1'b0;
        frag_load = 1'b0;
        frag_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                req_take = i_req.valid;
            end
            ST_FRAG: begin
                frag_load = out_free;
                frag_done = out_free && !r_err && !more;
            end
            default: begin
                req_take = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign cfg_rising  = i_cfg_data & ~r_mask;

    // State register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n201  <= LEN_W'(500);
            r_mask  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == REG_LLC_MAX_INFO_LEN) begin
                r_n201 <= i_cfg_data[LEN_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_ACTIVE_NSAPI_MASK) begin
                r_mask <= i_cfg_data[NSAPI_COUNT-1:0];
            end
        end
    end

    // N-PDU counters: cleared on activation, advanced once per N-PDU sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSAPI_COUNT; i++) begin
                r_npdu_cnt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NSAPI_COUNT; i++) begin
                if (i_cfg_we && i_cfg_index == REG_ACTIVE_NSAPI_MASK && cfg_rising[i]) begin
                    r_npdu_cnt[i] <= '0;
                end else if (frag_done && r_ns == NSAPI_W'(i)) begin
                    r_npdu_cnt[i] <= r_npdu + NPDU_W'(1);
                end
            end
        end
    end

    // Working registers: loaded on request, stepped per fragment
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_err       <= !r_mask[i_req.nsapi];
            r_ns        <= i_req.nsapi;
            r_npdu      <= r_npdu_cnt[i_req.nsapi];
            r_cap_first <= n201_eff - LEN_W'(4);
            r_rem       <= len_sat;
            r_offset    <= '0;
            r_idx       <= '0;
        end else if (frag_load) begin
            r_rem    <= rem_after;
            r_offset <= r_offset + take;
            r_idx    <= r_idx + SEG_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frag_load) begin
            r_out_valid <= 1'b1;
        end else if (o_frag.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frag_load) begin
            if (r_err) begin
                r_status   <= STATUS_INACTIVE;
                r_first    <= 1'b0;
                r_more     <= 1'b0;
                r_seg      <= '0;
                r_out_npdu <= '0;
                r_out_off  <= '0;
                r_out_len  <= '0;
                r_hdr      <= '0;
                r_last     <= 1'b1;
            end else begin
                r_status   <= STATUS_OK;
                r_first    <= (r_idx == '0);
                r_more     <= (rem_after != '0);
                r_seg      <= r_idx;
                r_out_npdu <= r_npdu;
                r_out_off  <= r_offset;
                r_out_len  <= take;
                r_hdr      <= (r_idx == '0) ? HDR_LEN_FIRST : HDR_LEN_LATER;
                r_last     <= !more;
            end
        end
    end

    assign o_frag.valid          = r_out_valid;
    assign o_frag.status         = r_status;
    assign o_frag.first_flag     = r_first;
    assign o_frag.more_flag      = r_more;
    assign o_frag.segment_number = r_seg;
    assign o_frag.npdu_number    = r_out_npdu;
    assign o_frag.payload_offset = r_out_off;
    assign o_frag.payload_length = r_out_len;
    assign o_frag.header_length  = r_hdr;
    assign o_frag.last_result    = r_last;

endmodule
